// ----- design/ffba_pkg.sv -----
// Package for the first-fit block allocator: status codes, command codes and
// sequencer states. No dependencies.
`default_nettype none
package ffba_pkg;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASCAN,
    S_ARD,
    S_AUPD,
    S_GSCAN,
    S_GRD,
    S_FSCAN,
    S_FRD,
    S_MERGE,
    S_MOVE,
    S_GDROP,
    S_GMOVE,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- design/first_fit_block_allocator.sv -----
// First-fit block allocator top level: free and grant tables, sequencer and
// result register. Depends on ffba_pkg.
`default_nettype none
// One command word in, one result word out. Allocate scans the free table one
// entry per cycle until the first extent that fits. Free walks the grant table
// entry by entry (registered memory read, then compare) to find the block, then
// scans the whole free table for neighbours one entry per cycle, then merges
// and compacts. in_tready is low while a command is at work and while a result
// waits in the output register. The grant table is a memory with one
// registered read port; the free table lives in registers.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int HEAP_BYTES    = 65536,
  parameter int GRANT_ENTRIES = 16,
  parameter int FREE_ENTRIES  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // cmd[0], req_size[17:1], req_addr[33:18]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // result_addr[15:0], status[18:16]
);
  localparam int GW = (GRANT_ENTRIES > 1) ? $clog2(GRANT_ENTRIES) : 1;
  localparam int FW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int GC = $clog2(GRANT_ENTRIES + 1);
  localparam int FC = $clog2(FREE_ENTRIES + 1);
  localparam logic [16:0] HEAP_LEN = 17'(HEAP_BYTES);

  state_t state_r, state_nxt;

  // free table in registers
  logic [15:0] fs_r [FREE_ENTRIES];
  logic [16:0] fl_r [FREE_ENTRIES];
  logic [FC-1:0] fcnt_r;
  // grant table memory
  logic [15:0] gs_mem [GRANT_ENTRIES];
  logic [16:0] gl_mem [GRANT_ENTRIES];
  logic [GC-1:0] gcnt_r;
  logic [15:0] grd_s_r;
  logic [16:0] grd_l_r;

  logic        cmd_r;
  logic [16:0] size_r;
  logic [15:0] addr_r;
  logic [GC-1:0] gi_r;          // grant walk index
  logic [FC-1:0] fi_r;          // free walk index
  logic [FW-1:0] cur_r;         // matched free entry (allocate)
  logic [15:0] bs_r;            // freed block start
  logic [16:0] bl_r;            // freed block length
  logic        hl_r, hr_r;
  logic [FW-1:0] left_r, right_r;
  logic [16:0] nlen_r;          // remaining extent length after allocate
  logic [15:0] nst_r;
  logic [15:0] res_addr_r;
  status_t     res_st_r;
  logic        ovalid_r;

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, res_st_r, res_addr_r};

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // end sums (17-bit adds) for the free entry at fi_r and the freed block, used by the scans
  logic [FW-1:0] fidx;
  assign fidx = fi_r[FW-1:0];
  logic [16:0] fend;
  assign fend = {1'b0, fs_r[fidx]} + fl_r[fidx];
  logic [16:0] bend;
  assign bend = {1'b0, bs_r} + bl_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (in_tdata[0] == CMD_FREE) ? S_GSCAN : S_ASCAN;
      S_ASCAN: begin
        if (size_r == 17'd0 || gcnt_r == GC'(GRANT_ENTRIES) || fi_r >= fcnt_r)
          state_nxt = S_DONE;
        else if (fl_r[fidx] >= size_r) state_nxt = S_ARD;
      end
      S_ARD:   state_nxt = S_AUPD;
      S_AUPD:  state_nxt = (nlen_r == 17'd0) ? S_MOVE : S_DONE;
      S_GSCAN: state_nxt = (gi_r >= gcnt_r) ? S_DONE : S_GRD;
      S_GRD:   state_nxt = (grd_s_r == addr_r) ? S_FSCAN : S_GSCAN;
      S_FSCAN: if (fi_r >= fcnt_r) state_nxt = S_MERGE;
      S_MERGE: begin
        if (hl_r && hr_r) state_nxt = S_MOVE;
        else if (!hl_r && !hr_r && fcnt_r == FC'(FREE_ENTRIES)) state_nxt = S_DONE;
        else state_nxt = S_GDROP;
      end
      S_MOVE:  state_nxt = cmd_r ? S_GDROP : S_DONE;
      S_GDROP: state_nxt = S_GMOVE;
      S_GMOVE: state_nxt = S_DONE;
      S_FRD:   state_nxt = S_MERGE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // grant memory: registered read, single write
  logic [GW-1:0] grd_idx;
  always_comb begin
    grd_idx = gi_r[GW-1:0];
    if (state_r == S_GDROP) grd_idx = GW'(gcnt_r - GC'(1));
  end
  always_ff @(posedge clk) begin
    grd_s_r <= gs_mem[grd_idx];
    grd_l_r <= gl_mem[grd_idx];
    if (state_r == S_ARD) begin
      gs_mem[gcnt_r[GW-1:0]] <= fs_r[cur_r];
      gl_mem[gcnt_r[GW-1:0]] <= size_r;
    end else if (state_r == S_GMOVE) begin
      gs_mem[gi_r[GW-1:0]] <= grd_s_r;
      gl_mem[gi_r[GW-1:0]] <= grd_l_r;
    end
  end

  logic [FW-1:0] flast;
  assign flast = FW'(fcnt_r - FC'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r     <= FC'(1);
      gcnt_r     <= '0;
      ovalid_r   <= 1'b0;
      fs_r[0]    <= '0;
      fl_r[0]    <= HEAP_LEN;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          cmd_r  <= in_tdata[0];
          size_r <= in_tdata[17:1];
          addr_r <= in_tdata[33:18];
          gi_r   <= '0;
          fi_r   <= '0;
          hl_r   <= 1'b0;
          hr_r   <= 1'b0;
          res_addr_r <= '0;
          res_st_r   <= ST_OOM;
        end
        S_ASCAN: begin
          if (size_r == 17'd0) res_st_r <= ST_ZERO;
          else if (gcnt_r == GC'(GRANT_ENTRIES)) res_st_r <= ST_FULL;
          else if (fi_r < fcnt_r && fl_r[fidx] >= size_r) begin
            cur_r  <= fidx;
            nlen_r <= fl_r[fidx] - size_r;
            nst_r  <= 16'(fend - fl_r[fidx] + size_r);
          end else fi_r <= fi_r + FC'(1);
        end
        S_ARD: begin
          gcnt_r     <= gcnt_r + GC'(1);
          res_addr_r <= fs_r[cur_r];
          res_st_r   <= ST_OK;
        end
        S_AUPD: begin
          fs_r[cur_r] <= nst_r;
          fl_r[cur_r] <= nlen_r;
          right_r     <= cur_r;
        end
        S_GSCAN: if (gi_r >= gcnt_r) res_st_r <= ST_UNKNOWN;
        S_GRD: begin
          if (grd_s_r == addr_r) begin
            bs_r <= grd_s_r;
            bl_r <= grd_l_r;
          end else gi_r <= gi_r + GC'(1);
        end
        S_FSCAN: if (fi_r < fcnt_r) begin
          if (!hl_r && fend == {1'b0, bs_r}) begin
            hl_r <= 1'b1; left_r <= fidx;
          end
          if (!hr_r && {1'b0, fs_r[fidx]} == bend) begin
            hr_r <= 1'b1; right_r <= fidx;
          end
          fi_r <= fi_r + FC'(1);
        end
        S_MERGE: begin
          if (hl_r && hr_r)
            fl_r[left_r] <= fl_r[left_r] + bl_r + fl_r[right_r];
          else if (hl_r)
            fl_r[left_r] <= fl_r[left_r] + bl_r;
          else if (hr_r) begin
            fs_r[right_r] <= bs_r;
            fl_r[right_r] <= fl_r[right_r] + bl_r;
          end else if (fcnt_r == FC'(FREE_ENTRIES))
            res_st_r <= ST_FULL;
          else begin
            fs_r[fcnt_r[FW-1:0]] <= bs_r;
            fl_r[fcnt_r[FW-1:0]] <= bl_r;
            fcnt_r <= fcnt_r + FC'(1);
          end
        end
        S_MOVE: begin
          // fill the hole at right_r with the last extent
          fs_r[right_r] <= fs_r[flast];
          fl_r[right_r] <= fl_r[flast];
          fcnt_r <= fcnt_r - FC'(1);
        end
        S_GDROP: ;
        S_GMOVE: begin
          gcnt_r     <= gcnt_r - GC'(1);
          res_addr_r <= addr_r;
          res_st_r   <= ST_OK;
        end
        S_FRD: ;
        S_DONE: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FC'(FREE_ENTRIES) && gcnt_r <= GC'(GRANT_ENTRIES))
    else $error("table count out of range");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE && !ovalid_r)
    else $error("ready while busy");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> ovalid_r)
    else $error("result not raised");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && res_st_r != ST_OK |-> res_addr_r == 16'd0)
    else $error("failure with nonzero address");
`endif
endmodule
`default_nettype wire

// ----- test/tb_first_fit_block_allocator.sv -----
// Self-checking testbench for first_fit_block_allocator: drives allocate and free
// commands, predicts each result word and compares it. Depends on ffba_pkg.
`default_nettype none
module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int HEAP     = 65536;
  localparam int NGRANT   = 16;
  localparam int NFREE    = 16;
  localparam int LIMIT    = 400000;
  localparam int SETTLE   = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // cmd[0], req_size[17:1], req_addr[33:18]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // result_addr[15:0], status[18:16]

  first_fit_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator tables
  logic [15:0] fr_start [NFREE];
  logic [16:0] fr_len   [NFREE];
  int          fr_cnt;
  logic [15:0] gr_start [NGRANT];
  logic [16:0] gr_len   [NGRANT];
  int          gr_cnt;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
  } result_t;

  result_t     pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          sender_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int          sink_hold = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_taken = 1'b0;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_first_fit_block_allocator: errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      sink_hold <= 300;
      out_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result word against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result addr=%h status=%0d", out_tdata[15:0], out_tdata[18:16]);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.addr || out_tdata[18:16] !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want addr=%h status=%0d, got addr=%h status=%0d",
                     want.addr, want.status, out_tdata[15:0], out_tdata[18:16]);
        end
      end
    end
  end

  task automatic model_reset();
    fr_cnt = 1;
    fr_start[0] = '0;
    fr_len[0] = 17'(HEAP);
    gr_cnt = 0;
  endtask

  function automatic void drop_free_entry(int idx);
    fr_start[idx] = fr_start[fr_cnt-1];
    fr_len[idx] = fr_len[fr_cnt-1];
    fr_cnt--;
  endfunction

  // Predict one allocate or free and update the shadow tables
  function automatic result_t predict_allocator(logic cmd, logic [16:0] size, logic [15:0] a);
    result_t r;
    int g, left, right;
    logic [16:0] len;
    logic [16:0] tail;
    r.addr = '0;
    if (cmd == CMD_ALLOC) begin
      r.status = ST_OOM;
      if (size == 0) return '{addr: '0, status: ST_ZERO};
      if (gr_cnt >= NGRANT) return '{addr: '0, status: ST_FULL};
      for (int i = 0; i < fr_cnt; i++) begin
        if (fr_len[i] >= size) begin
          r.addr = fr_start[i];
          r.status = ST_OK;
          gr_start[gr_cnt] = fr_start[i];
          gr_len[gr_cnt] = size;
          gr_cnt++;
          fr_start[i] = fr_start[i] + size[15:0];
          fr_len[i] = fr_len[i] - size;
          if (fr_len[i] == 0) drop_free_entry(i);
          return r;
        end
      end
      return r;
    end
    g = -1;
    for (int i = 0; i < gr_cnt; i++)
      if (g < 0 && gr_start[i] == a) g = i;
    if (g < 0) return '{addr: '0, status: ST_UNKNOWN};
    len = gr_len[g];
    tail = {1'b0, a} + len;
    left = -1;
    right = -1;
    for (int j = 0; j < fr_cnt; j++) begin
      if (left < 0 && ({1'b0, fr_start[j]} + fr_len[j]) == {1'b0, a}) left = j;
      if (right < 0 && {1'b0, fr_start[j]} == tail) right = j;
    end
    if (left >= 0 && right >= 0) begin
      fr_len[left] = fr_len[left] + len + fr_len[right];
      drop_free_entry(right);
    end else if (left >= 0) begin
      fr_len[left] = fr_len[left] + len;
    end else if (right >= 0) begin
      fr_start[right] = a;
      fr_len[right] = fr_len[right] + len;
    end else begin
      if (fr_cnt >= NFREE) return '{addr: '0, status: ST_FULL};
      fr_start[fr_cnt] = a;
      fr_len[fr_cnt] = len;
      fr_cnt++;
    end
    gr_start[g] = gr_start[gr_cnt-1];
    gr_len[g] = gr_len[gr_cnt-1];
    gr_cnt--;
    return '{addr: a, status: ST_OK};
  endfunction

  // Offer one command word, with an optional idle burst, and wait for acceptance;
  // hold tvalid high afterwards so back-to-back words follow without a gap
  task automatic send_command(logic cmd, logic [16:0] size, logic [15:0] a);
    if (sender_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, a, size, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_allocator(cmd, size, a));
  endtask

  // Drop tvalid and wait for every expected result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Free a random live grant, or now and then a stray offset
  task automatic free_something();
    if (gr_cnt > 0 && $urandom_range(0, 9) != 0)
      send_command(CMD_FREE, 17'($urandom), gr_start[$urandom_range(0, gr_cnt-1)]);
    else
      send_command(CMD_FREE, 17'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_command(CMD_ALLOC, 17'd0, 16'hFFFF);        // zero size
    send_command(CMD_ALLOC, 17'h1FFFF, 16'd0);       // larger than heap
    send_command(CMD_FREE, 17'd0, 16'd0);            // unknown address
    send_command(CMD_ALLOC, 17'(HEAP), 16'd0);      // whole heap, extent dropped
    send_command(CMD_ALLOC, 17'd1, 16'd0);           // empty free table
    send_command(CMD_FREE, 17'h1FFFF, 16'd0);
    for (int i = 0; i < 17; i++)                     // fill grant table, then full
      send_command(CMD_ALLOC, 17'd16, 16'($urandom));
    send_command(CMD_FREE, 17'd0, 16'd16);           // no free neighbour
    send_command(CMD_FREE, 17'd0, 16'd48);
    send_command(CMD_FREE, 17'd0, 16'd32);           // both neighbours free
    send_command(CMD_FREE, 17'd0, 16'd0);            // right neighbour only
    wait_drained();
  endtask

  // Chop the heap into isolated holes so the free table fills up
  task automatic test_free_table_full();
    for (int i = 0; i < 32; i++) free_something();
    for (int i = 0; i < 16; i++) send_command(CMD_ALLOC, 17'd1, 16'd0);
    for (int k = 0; k < 8; k++) send_command(CMD_FREE, 17'd0, 16'(2 * k));
    send_command(CMD_ALLOC, 17'h1FFFF, 16'd0);
    for (int i = 0; i < 40; i++) free_something();
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [16:0] size;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 50) begin
        case ($urandom_range(0, 5))
          0: size = 17'($urandom);
          1: size = 17'($urandom_range(0, 3));
          2: size = 17'($urandom_range(1, 4096));
          default: size = 17'($urandom_range(1, 256));
        endcase
        send_command(CMD_ALLOC, size, 16'($urandom));
      end else begin
        free_something();
      end
    end
  endtask

  // Stall the receiver long enough that the input side backs up
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    test_random(20);
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_free_table_full();
    test_random(900);
    test_backpressure();
    test_random(600);
    wait_drained();
    sender_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(300);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("tb_first_fit_block_allocator: clean");
    else
      $display("tb_first_fit_block_allocator: errors");
    $finish;
  end
endmodule
`default_nettype wire
